// ----- design/wclm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wclm_pkg
// Shared types, codes and wildcard helpers for the code list matcher.
// ----------------------------------------------------------------------------
package wclm_pkg;

    localparam int CodeWidth = 32;

    typedef logic [CodeWidth-1:0] code_t;

    localparam code_t CODE_STAR    = 32'h2A00_0000;
    localparam code_t CODE_INVERSE = 32'h2100_0000;

    localparam code_t MASK_ALL  = 32'h0000_0000;
    localparam code_t MASK_B3   = 32'hFF00_0000;
    localparam code_t MASK_B32  = 32'hFFFF_0000;
    localparam code_t MASK_B321 = 32'hFFFF_FF00;
    localparam code_t MASK_NONE = 32'hFFFF_FFFF;

    localparam logic [7:0] WILD_BYTE = 8'h2A;

    typedef struct packed {
        logic polarity;
        logic decided;
        logic decided_value;
    } match_state_t;

    localparam match_state_t STATE_RESET = '{polarity: 1'b1, decided: 1'b0,
                                            decided_value: 1'b0};

    // first star byte masks itself and everything after it
    function automatic code_t wildcard_mask(input code_t code);
        code_t m;
        if (code[31:24] == WILD_BYTE)
            m = MASK_ALL;
        else if (code[23:16] == WILD_BYTE)
            m = MASK_B3;
        else if (code[15:8] == WILD_BYTE)
            m = MASK_B32;
        else if (code[7:0] == WILD_BYTE)
            m = MASK_B321;
        else
            m = MASK_NONE;
        return m;
    endfunction

    function automatic logic code_covered(input code_t src, input code_t pat);
        code_t smask;
        code_t pmask;
        logic  hit;
        smask = wildcard_mask(src);
        pmask = wildcard_mask(pat);
        hit = (src == pat)
            || ((smask != MASK_NONE) && ((pat & smask) == (src & smask)))
            || ((src & pmask) == (pat & pmask));
        return hit;
    endfunction

endpackage

// ----- design/wclm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wclm_if
// Valid/ready channels for pattern entries and match results.
// ----------------------------------------------------------------------------
interface wclm_entry_if
    import wclm_pkg::*;
();
    logic  valid;
    logic  ready;
    code_t source_code;
    code_t pattern_code;
    logic  entry_valid;
    logic  last_entry;

    modport source (output valid, output source_code, output pattern_code,
                    output entry_valid, output last_entry, input ready);
    modport sink   (input valid, input source_code, input pattern_code,
                    input entry_valid, input last_entry, output ready);
endinterface

interface wclm_result_if;
    logic valid;
    logic ready;
    logic matches_res;

    modport source (output valid, output matches_res, input ready);
    modport sink   (input valid, input matches_res, output ready);
endinterface

// ----- design/wildcard_code_list_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_code_list_match
// Tests a four-byte code against a streamed wildcard pattern list.
// ----------------------------------------------------------------------------
// Usage:
//   pattern  : one list entry per word (source code, pattern code, entry
//              valid flag, last flag). A word with entry_valid low is skipped.
//   result   : one word per list, carrying matches_res, sent after the word
//              flagged last_entry.
//   Path     : a last word passes the input register, then the result register.
//   Throughput: one word per cycle while no last word waits on a pending result;
//              the list state is a single 3-bit loop through the entry
//              evaluator, so lists may follow each other without gaps.
//   Reset    : clears the input and result valid flags and sets the list state
//              to polarity 1, nothing decided.
//   Stall    : a result waiting on the receiver holds the result register;
//              non-last words keep flowing into the list state, and only a
//              last word waits in the input register until the result goes.
// ----------------------------------------------------------------------------
module wildcard_code_list_match
    import wclm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    wclm_entry_if.sink   pattern,
    wclm_result_if.source result
);

    logic         in_valid_reg;
    code_t        src_reg;
    code_t        pat_reg;
    logic         entry_valid_reg;
    logic         last_reg;

    match_state_t state_reg;
    match_state_t state_next;
    match_state_t eval_next;
    logic         eval_answer;

    logic         out_valid_reg;
    logic         out_valid_next;
    logic         out_match_reg;

    logic         advance;
    logic         close_list;

    // a last word may only leave when the result slot is free
    assign advance    = in_valid_reg && (!last_reg || !out_valid_reg || result.ready);
    assign close_list = advance && last_reg;
    assign pattern.ready = !in_valid_reg || advance;

    wclm_entry_eval u_eval (
        .state        (state_reg),
        .source_code  (src_reg),
        .pattern_code (pat_reg),
        .entry_valid  (entry_valid_reg),
        .state_next   (eval_next),
        .answer       (eval_answer)
    );

    always_comb
    begin
        if (close_list)
            state_next = STATE_RESET;
        else if (advance)
            state_next = eval_next;
        else
            state_next = state_reg;
    end

    always_comb
    begin
        if (close_list)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pattern.ready)
                in_valid_reg <= pattern.valid;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pattern.valid && pattern.ready)
        begin
            src_reg         <= pattern.source_code;
            pat_reg         <= pattern.pattern_code;
            entry_valid_reg <= pattern.entry_valid;
            last_reg        <= pattern.last_entry;
        end
        if (close_list)
            out_match_reg <= eval_answer;
    end

    assign result.valid       = out_valid_reg;
    assign result.matches_res = out_match_reg;

    a_close_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
        close_list |=> (state_reg.polarity && !state_reg.decided))
        else $error("list state not restored after last word");

    a_close_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        close_list |=> out_valid_reg)
        else $error("result not posted after last word");

    a_decided_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.decided && !close_list) |=> state_reg.decided)
        else $error("decision lost inside a list");

    a_polarity_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.decided && !close_list) |=>
            (state_reg.polarity == $past(state_reg.polarity)))
        else $error("polarity changed after a match");

endmodule

// ----- design/wclm_entry_eval.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wclm_entry_eval
// Applies one list entry to the running match state.
// ----------------------------------------------------------------------------
module wclm_entry_eval
    import wclm_pkg::*;
(
    input  match_state_t state,
    input  code_t        source_code,
    input  code_t        pattern_code,
    input  logic         entry_valid,
    output match_state_t state_next,
    output logic         answer
);

    always_comb
    begin
        state_next = state;
        if (entry_valid && !state.decided)
        begin
            if (pattern_code == CODE_STAR)
            begin
                state_next.decided       = 1'b1;
                state_next.decided_value = state.polarity;
            end
            else if (pattern_code == CODE_INVERSE)
            begin
                state_next.polarity = ~state.polarity;
            end
            else if (code_covered(source_code, pattern_code))
            begin
                state_next.decided       = 1'b1;
                state_next.decided_value = state.polarity;
            end
        end
    end

    // no match: inverse of the final polarity
    assign answer = state_next.decided ? state_next.decided_value : ~state_next.polarity;

endmodule
